// ===== sv/rfou_pkg.sv =====
`default_nettype none
package rfou_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD_START,
    ST_GCD_RUN,
    ST_RED1_START,
    ST_RED1_RUN,
    ST_RED2_START,
    ST_RED2_RUN,
    ST_QR_START,
    ST_QR_RUN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIVSEL_GCD,
    DIVSEL_RED_MAG,
    DIVSEL_RED_DEN,
    DIVSEL_QR
  } divsel_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    comb;
    logic    div_start;
    divsel_t div_sel;
    logic    gcd_step;
    logic    red_mag;
    logic    red_den;
    logic    qr_take;
    logic    out_valid;
  } cmd_t;

  typedef struct packed {
    logic inf;
    logic div_done;
    logic gcd_zero;
    logic out_taken;
  } sts_t;

  localparam int unsigned WIDE = 64;
endpackage
`default_nettype wire

// ===== sv/rfou_ctrl.sv =====
`default_nettype none
module rfou_ctrl
  import rfou_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_fire) state_nxt = ST_MUL;
      ST_MUL:        state_nxt = sts.inf ? ST_OUT : ST_COMB;
      ST_COMB:       state_nxt = ST_GCD_START;
      ST_GCD_START:  state_nxt = sts.gcd_zero ? ST_RED1_START : ST_GCD_RUN;
      ST_GCD_RUN:    if (sts.div_done) state_nxt = ST_GCD_START;
      ST_RED1_START: state_nxt = ST_RED1_RUN;
      ST_RED1_RUN:   if (sts.div_done) state_nxt = ST_RED2_START;
      ST_RED2_START: state_nxt = ST_RED2_RUN;
      ST_RED2_RUN:   if (sts.div_done) state_nxt = ST_QR_START;
      ST_QR_START:   state_nxt = ST_QR_RUN;
      ST_QR_RUN:     if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:        if (sts.out_taken) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIVSEL_GCD;
    busy = (state_r != ST_IDLE);
    cmd.load = (state_r == ST_IDLE) && in_fire;
    unique case (state_r)
      ST_MUL:  cmd.mul = 1'b1;
      ST_COMB: cmd.comb = 1'b1;
      ST_GCD_START: begin
        cmd.div_start = !sts.gcd_zero;
        cmd.div_sel   = DIVSEL_GCD;
      end
      ST_GCD_RUN: begin
        cmd.div_sel  = DIVSEL_GCD;
        cmd.gcd_step = sts.div_done;
      end
      ST_RED1_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIVSEL_RED_MAG;
      end
      ST_RED1_RUN: begin
        cmd.div_sel = DIVSEL_RED_MAG;
        cmd.red_mag = sts.div_done;
      end
      ST_RED2_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIVSEL_RED_DEN;
      end
      ST_RED2_RUN: begin
        cmd.div_sel = DIVSEL_RED_DEN;
        cmd.red_den = sts.div_done;
      end
      ST_QR_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIVSEL_QR;
      end
      ST_QR_RUN: begin
        cmd.div_sel = DIVSEL_QR;
        cmd.qr_take = sts.div_done;
      end
      ST_OUT:  cmd.out_valid = 1'b1;
      default: cmd.out_valid = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/rfou_div.sv =====
`default_nettype none
module rfou_div
  import rfou_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDE-1:0]   dividend,
  input  wire logic [WIDE-1:0]   divisor,
  output logic                   done,
  output logic      [WIDE-1:0]   quotient,
  output logic      [WIDE-1:0]   remainder
);
  localparam int unsigned CW = $clog2(WIDE + 1);

  logic [WIDE-1:0] q_r, q_nxt;
  logic [WIDE:0]   rem_r, rem_nxt;
  logic [WIDE-1:0] d_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic [WIDE:0]   trial;
  logic [WIDE:0]   diff;

  always_comb begin
    trial   = {rem_r[WIDE-1:0], q_r[WIDE-1]};
    diff    = trial - {1'b0, d_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(WIDE);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[WIDE]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[WIDE-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[WIDE-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign done      = run_r && (cnt_r == CW'(1));
  assign quotient  = q_nxt;
  assign remainder = rem_nxt[WIDE-1:0];
endmodule
`default_nettype wire

// ===== sv/rfou_dp.sv =====
`default_nettype none
module rfou_dp
  import rfou_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        out_tready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_ln,
  input  wire logic [30:0] in_ld,
  input  wire logic [31:0] in_rn,
  input  wire logic [30:0] in_rd,
  output logic [63:0]      whole_part,
  output logic [63:0]      fraction_numerator,
  output logic [62:0]      fraction_denominator,
  output logic             is_infinite
);
  localparam int unsigned NW = OPERAND_WIDTH;
  localparam int unsigned DW = OPERAND_WIDTH - 1;

  op_t           op_r;
  logic [NW-1:0] lmag_r, rmag_r;
  logic [DW-1:0] ld_r, rd_r;
  logic          lneg_r, rneg_r, inf_r;
  logic [WIDE-1:0] p1_r, p2_r, p3_r, mag_r, den_r, ga_r, gb_r;
  logic          neg_r;

  logic [NW-1:0] ln_w, rn_w, lmag_w, rmag_w;
  logic [DW-1:0] ld_w, rd_w;
  logic          lneg_w, rneg_w, rneg_e;

  logic            div_start, div_done;
  logic [WIDE-1:0] div_a, div_b, div_q, div_rm;

  assign ln_w   = in_ln[NW-1:0];
  assign rn_w   = in_rn[NW-1:0];
  assign ld_w   = in_ld[DW-1:0];
  assign rd_w   = in_rd[DW-1:0];
  assign lneg_w = ln_w[NW-1];
  assign rneg_w = rn_w[NW-1];
  assign lmag_w = lneg_w ? (~ln_w + NW'(1)) : ln_w;
  assign rmag_w = rneg_w ? (~rn_w + NW'(1)) : rn_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      lmag_r <= lmag_w;
      rmag_r <= rmag_w;
      ld_r   <= ld_w;
      rd_r   <= rd_w;
      lneg_r <= lneg_w;
      rneg_r <= rneg_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_r <= 1'b0;
    end else if (cmd.load) begin
      inf_r <= (ld_w == '0) || (rd_w == '0)
               || ((op_t'(in_op) == OP_DIV) && (rmag_w == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (op_r == OP_MUL) begin
        p1_r <= WIDE'(lmag_r) * WIDE'(rmag_r);
      end else begin
        p1_r <= WIDE'(lmag_r) * WIDE'(rd_r);
      end
      p2_r <= WIDE'(rmag_r) * WIDE'(ld_r);
      p3_r <= WIDE'(ld_r) * WIDE'(rd_r);
    end
  end

  assign rneg_e = (op_r == OP_SUB) ? !rneg_r : rneg_r;

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      logic [WIDE-1:0] m;
      logic            n;
      m = p1_r;
      n = lneg_r ^ rneg_r;
      unique case (op_r)
        OP_ADD, OP_SUB: begin
          den_r <= p3_r;
          gb_r  <= p3_r;
          if (lneg_r == rneg_e) begin
            m = p1_r + p2_r;
            n = lneg_r;
          end else if (p1_r >= p2_r) begin
            m = p1_r - p2_r;
            n = lneg_r;
          end else begin
            m = p2_r - p1_r;
            n = rneg_e;
          end
        end
        OP_MUL: begin
          den_r <= p3_r;
          gb_r  <= p3_r;
        end
        default: begin
          den_r <= p2_r;
          gb_r  <= p2_r;
        end
      endcase
      mag_r <= m;
      ga_r  <= m;
      neg_r <= n && (m != '0);
    end else if (cmd.gcd_step) begin
      ga_r <= gb_r;
      gb_r <= div_rm;
    end else if (cmd.red_mag) begin
      mag_r <= div_q;
    end else if (cmd.red_den) begin
      den_r <= div_q;
    end
  end

  always_comb begin
    div_a = ga_r;
    div_b = gb_r;
    unique case (cmd.div_sel)
      DIVSEL_GCD:     begin div_a = ga_r;  div_b = gb_r;  end
      DIVSEL_RED_MAG: begin div_a = mag_r; div_b = ga_r;  end
      DIVSEL_RED_DEN: begin div_a = den_r; div_b = ga_r;  end
      default:        begin div_a = mag_r; div_b = den_r; end
    endcase
  end

  assign div_start = cmd.div_start;

  rfou_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      whole_part           <= '0;
      fraction_numerator   <= '0;
      fraction_denominator <= 63'd1;
    end else if (cmd.qr_take) begin
      whole_part           <= neg_r ? (WIDE'(0) - div_q) : div_q;
      fraction_numerator   <= (neg_r && (div_q == '0)) ? (WIDE'(0) - div_rm) : div_rm;
      fraction_denominator <= den_r[62:0];
    end
  end

  assign is_infinite   = inf_r;
  assign sts.inf       = inf_r;
  assign sts.div_done  = div_done;
  assign sts.gcd_zero  = (gb_r == '0);
  assign sts.out_taken = cmd.out_valid && out_tready;
endmodule
`default_nettype wire

// ===== sv/rational_four_op_unit.sv =====
`default_nettype none
// Exact add, subtract, multiply or divide of two fractions, giving a whole part truncated
// toward zero and a fully reduced remainder fraction. One item is processed at a time. A
// finite result is computed by the shared radix-2 divider: each pass is a start followed
// by one quotient bit per step, and it runs once per Euclid GCD step and three more times
// for reduction and the quotient. An infinite result skips the divider and goes from the
// multiply state straight to the output state.
module rational_four_op_unit
  import rfou_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation[1:0], left_numerator[33:2], left_denominator[64:34],
  // right_numerator[96:65], right_denominator[127:97]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // whole_part[63:0], fraction_numerator[127:64], fraction_denominator[190:128]
  output logic [191:0]      out_tdata,
  // is_infinite
  output logic              out_tuser
);
  cmd_t        cmd;
  sts_t        sts;
  logic        busy, in_fire;
  logic [63:0] whole, fnum;
  logic [62:0] fden;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  rfou_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  rfou_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_tready           (out_tready),
    .in_op                (in_tdata[1:0]),
    .in_ln                (in_tdata[33:2]),
    .in_ld                (in_tdata[64:34]),
    .in_rn                (in_tdata[96:65]),
    .in_rd                (in_tdata[127:97]),
    .whole_part           (whole),
    .fraction_numerator   (fnum),
    .fraction_denominator (fden),
    .is_infinite          (out_tuser)
  );

  assign out_tvalid = cmd.out_valid;
  assign out_tdata  = {1'b0, fden, fnum, whole};
endmodule
`default_nettype wire
